/* design/ite_pkg.sv */
// Shared types, constants and helper functions for the timestamp to epoch converter.
package ite_pkg;

  localparam int CHAR_W   = 8;
  localparam int EPOCH_W  = 39;
  localparam int POS_W    = 5;
  localparam int YEAR_W   = 14;
  localparam int FLD_W    = 7;
  localparam int NUM_FLD  = 8;
  localparam int HMS_W    = 21;
  localparam int DAYS_W   = 24;
  localparam int DOE_W    = 19;
  localparam int DOY_W    = 13;
  localparam int ERA_W    = 6;
  localparam int YOE_W    = 9;

  localparam int CALC_CYCLES = 5;
  localparam int CNT_W       = 3;

  localparam logic [POS_W-1:0] POS_LIMIT  = 5'd25;
  localparam logic [POS_W-1:0] MIN_LEN    = 5'd19;
  localparam logic [POS_W-1:0] OFFSET_LEN = 5'd24;
  localparam logic [POS_W-1:0] COLON_LEN  = 5'd25;
  localparam logic [POS_W-1:0] YEAR_LEN   = 5'd4;
  localparam logic [POS_W-1:0] POS_SIGN   = 5'd19;
  localparam logic [POS_W-1:0] POS_COLON  = 5'd22;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;

  // Two-character fields after the year, in this order.
  localparam int FLD_MONTH   = 0;
  localparam int FLD_DAY     = 1;
  localparam int FLD_HOUR    = 2;
  localparam int FLD_MINUTE  = 3;
  localparam int FLD_SECOND  = 4;
  localparam int FLD_OHOUR   = 5;
  localparam int FLD_COMPACT = 6;
  localparam int FLD_COLON   = 7;

  localparam logic [POS_W-1:0] FLD_START [NUM_FLD] = '{
    5'd5, 5'd8, 5'd11, 5'd14, 5'd17, 5'd20, 5'd22, 5'd23
  };

  localparam logic signed [DAYS_W-1:0] DAYS_TO_1970 = 24'sd719468;

  typedef enum logic [1:0] {
    SIGN_NONE,
    SIGN_PLUS,
    SIGN_MINUS
  } sign_e;

  typedef enum logic [1:0] {
    ST_COLLECT,
    ST_CALC,
    ST_LOAD
  } ctrl_state_e;

  typedef struct packed {
    logic accept;
    logic last;
    logic load;
  } ite_cmd_t;

  // Floor of y / 400 for y below 10000: (y >> 4) / 25 by reciprocal 41 / 1024.
  function automatic logic [4:0] div400(input logic [YEAR_W-1:0] y);
    logic [15:0] prod;
    prod = 16'(y[YEAR_W-1:4]) * 16'd41;
    return 5'(prod >> 10);
  endfunction

  // Floor of x / 5 for x below 16384 by reciprocal 13108 / 65536.
  function automatic logic [11:0] div5(input logic [14:0] x);
    logic [28:0] prod;
    prod = 29'(x) * 29'd13108;
    return 12'(prod >> 16);
  endfunction

  // Floor of x / 100 for x below 400 by reciprocal 41 / 4096.
  function automatic logic [1:0] div100(input logic [YOE_W-1:0] x);
    logic [14:0] prod;
    prod = 15'(x) * 15'd41;
    return 2'(prod >> 12);
  endfunction

endpackage

/* design/ite_if.sv */
// Valid/ready channel interfaces for character input and epoch result output.
interface ite_in_if;
  import ite_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_text;

  modport source(output valid, output char_code, output end_of_text, input ready);
  modport sink(input valid, input char_code, input end_of_text, output ready);
endinterface

interface ite_out_if;
  import ite_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [EPOCH_W-1:0] epoch_seconds;
  logic                      too_short;

  modport source(output valid, output epoch_seconds, output too_short, input ready);
  modport sink(input valid, input epoch_seconds, input too_short, output ready);
endinterface

/* design/ite_ctrl.sv */
// Controller state machine: input handshake, conversion sequencing, output slot.
module ite_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  output logic              in_ready_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output ite_pkg::ite_cmd_t cmd_o
);
  import ite_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  logic             slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      ST_COLLECT: begin
        if (in_valid_i && in_last_i) begin
          state_d = ST_CALC;
          cnt_d   = '0;
        end
      end
      ST_CALC: begin
        if (cnt_q == CNT_W'(CALC_CYCLES - 1)) begin
          state_d = ST_LOAD;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_LOAD: begin
        if (slot_free) begin
          state_d = ST_COLLECT;
        end
      end
      default: state_d = ST_COLLECT;
    endcase
  end

  always_comb begin
    in_ready_o  = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_COLLECT: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        cmd_o.last   = in_valid_i && in_last_i;
      end
      ST_LOAD: begin
        cmd_o.load = slot_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_COLLECT;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  a_load_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (!out_valid_q || out_ready_i))
    else $error("result loaded over an untaken word");

  a_last_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.last |=> !in_ready_o)
    else $error("input not held off after final character");

  a_valid_from_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_o.load))
    else $error("output valid rose without a load");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CALC) |-> (cnt_q < CNT_W'(CALC_CYCLES)))
    else $error("conversion counter out of range");

endmodule

/* design/ite_dp.sv */
// Datapath: field collection per character and the five-stage civil-to-epoch conversion.
module ite_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [ite_pkg::CHAR_W-1:0]         char_code_i,
  input  ite_pkg::ite_cmd_t                  cmd_i,
  output logic signed [ite_pkg::EPOCH_W-1:0] epoch_seconds_o,
  output logic                               too_short_o
);
  import ite_pkg::*;

  // Collection state.
  logic [POS_W-1:0]  pos_q, pos_d, pos_upd;
  logic [YEAR_W-1:0] year_q, year_d, year_upd;
  logic [FLD_W-1:0]  fld_q [NUM_FLD];
  logic [FLD_W-1:0]  fld_d [NUM_FLD];
  logic [FLD_W-1:0]  fld_upd [NUM_FLD];
  logic [NUM_FLD:0]  ended_q, ended_d, ended_upd;
  sign_e             sign_q, sign_d, sign_upd;
  logic              colon_q, colon_d, colon_upd;

  logic              is_digit;
  logic [3:0]        digit;

  // Snapshot of one finished timestamp.
  logic [YEAR_W-1:0] s_year_q;
  logic [FLD_W-1:0]  s_month_q, s_day_q, s_hour_q, s_min_q, s_sec_q, s_oh_q, s_om_q;
  logic              s_neg_q, s_short_q;
  logic              tz_en;

  // Conversion stages.
  logic signed [14:0]        y1_q, y1_d;
  logic signed [ERA_W-1:0]   era1_q, era1_d;
  logic [14:0]               m153_q, m153_d;
  logic signed [HMS_W-1:0]   hms1_q, hms1_d;
  logic [FLD_W-1:0]          mp;
  logic                      le2;
  logic [18:0]               hms_pos, tz_secs;

  logic [YOE_W-1:0]          yoe2_q, yoe2_d;
  logic signed [DOY_W-1:0]   doy2_q, doy2_d;
  logic signed [DAYS_W-1:0]  eradays2_q, eradays2_d;
  logic signed [15:0]        era400, yoe_full;

  logic signed [DOE_W-1:0]   doe3_q, doe3_d;
  logic [17:0]               yoe365;

  logic signed [DAYS_W-1:0]  days4_q, days4_d;
  logic signed [EPOCH_W-1:0] secs5_q, secs5_d;

  logic signed [EPOCH_W-1:0] epoch_q;
  logic                      short_q;

  assign is_digit = (char_code_i >= CHAR_ZERO) && (char_code_i <= CHAR_NINE);
  assign digit    = 4'(char_code_i - CHAR_ZERO);

  // Each field takes digits from its start, and the first non-digit closes it.
  always_comb begin
    pos_upd   = pos_q;
    year_upd  = year_q;
    fld_upd   = fld_q;
    ended_upd = ended_q;
    sign_upd  = sign_q;
    colon_upd = colon_q;
    if (pos_q < POS_LIMIT) begin
      if ((pos_q < YEAR_LEN) && !ended_q[0]) begin
        if (is_digit) begin
          year_upd = YEAR_W'(year_q * 14'd10 + YEAR_W'(digit));
        end else begin
          ended_upd[0] = 1'b1;
        end
      end
      for (int k = 0; k < NUM_FLD; k++) begin
        if (((pos_q == FLD_START[k]) || (pos_q == FLD_START[k] + 5'd1)) && !ended_q[k+1]) begin
          if (is_digit) begin
            fld_upd[k] = FLD_W'(fld_q[k] * 7'd10 + FLD_W'(digit));
          end else begin
            ended_upd[k+1] = 1'b1;
          end
        end
      end
      if (pos_q == POS_SIGN) begin
        if (char_code_i == CHAR_PLUS) begin
          sign_upd = SIGN_PLUS;
        end else if (char_code_i == CHAR_MINUS) begin
          sign_upd = SIGN_MINUS;
        end else begin
          sign_upd = SIGN_NONE;
        end
      end
      if (pos_q == POS_COLON) begin
        colon_upd = (char_code_i == CHAR_COLON);
      end
      pos_upd = pos_q + 1'b1;
    end
  end

  always_comb begin
    pos_d   = pos_q;
    year_d  = year_q;
    fld_d   = fld_q;
    ended_d = ended_q;
    sign_d  = sign_q;
    colon_d = colon_q;
    if (cmd_i.last) begin
      pos_d   = '0;
      year_d  = '0;
      fld_d   = '{default: '0};
      ended_d = '0;
      sign_d  = SIGN_NONE;
      colon_d = 1'b0;
    end else if (cmd_i.accept) begin
      pos_d   = pos_upd;
      year_d  = year_upd;
      fld_d   = fld_upd;
      ended_d = ended_upd;
      sign_d  = sign_upd;
      colon_d = colon_upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      year_q  <= '0;
      fld_q   <= '{default: '0};
      ended_q <= '0;
      sign_q  <= SIGN_NONE;
      colon_q <= 1'b0;
    end else begin
      pos_q   <= pos_d;
      year_q  <= year_d;
      fld_q   <= fld_d;
      ended_q <= ended_d;
      sign_q  <= sign_d;
      colon_q <= colon_d;
    end
  end

  // The zone offset counts only for a long enough text with a sign character.
  assign tz_en = (pos_upd >= OFFSET_LEN) && (sign_upd != SIGN_NONE);

  always_ff @(posedge clk_i) begin
    if (cmd_i.last) begin
      s_year_q  <= year_upd;
      s_month_q <= fld_upd[FLD_MONTH];
      s_day_q   <= fld_upd[FLD_DAY];
      s_hour_q  <= fld_upd[FLD_HOUR];
      s_min_q   <= fld_upd[FLD_MINUTE];
      s_sec_q   <= fld_upd[FLD_SECOND];
      s_oh_q    <= tz_en ? fld_upd[FLD_OHOUR] : '0;
      s_om_q    <= !tz_en ? '0 :
                   ((pos_upd >= COLON_LEN) && colon_upd) ? fld_upd[FLD_COLON] :
                   fld_upd[FLD_COMPACT];
      s_neg_q   <= (sign_upd == SIGN_MINUS);
      s_short_q <= (pos_upd < MIN_LEN);
    end
  end

  // Stage 1: March-based year and month, era, time of day less the offset.
  assign le2     = (s_month_q <= 7'd2);
  assign mp      = le2 ? FLD_W'(s_month_q + 7'd9) : FLD_W'(s_month_q - 7'd3);
  assign hms_pos = 19'(s_hour_q) * 19'd3600 + 19'(s_min_q) * 19'd60 + 19'(s_sec_q);
  assign tz_secs = 19'(s_oh_q) * 19'd3600 + 19'(s_om_q) * 19'd60;

  always_comb begin
    y1_d   = $signed({1'b0, s_year_q}) - $signed({14'd0, le2});
    era1_d = (y1_d < 0) ? -6'sd1 : $signed({1'b0, div400(y1_d[YEAR_W-1:0])});
    m153_d = 15'(mp) * 15'd153 + 15'd2;
    if (s_neg_q) begin
      hms1_d = $signed(HMS_W'(hms_pos)) + $signed(HMS_W'(tz_secs));
    end else begin
      hms1_d = $signed(HMS_W'(hms_pos)) - $signed(HMS_W'(tz_secs));
    end
  end

  // Stage 2: year of era, day of year, days of whole eras.
  assign era400   = 16'(era1_q) * 16'sd400;
  assign yoe_full = 16'(y1_q) - era400;

  always_comb begin
    yoe2_d     = yoe_full[YOE_W-1:0];
    doy2_d     = $signed({1'b0, div5(m153_q)}) + $signed({6'd0, s_day_q}) - 13'sd1;
    eradays2_d = DAYS_W'(era1_q) * 24'sd146097;
  end

  // Stage 3: day of era.
  assign yoe365 = 18'(yoe2_q) * 18'd365;

  always_comb begin
    doe3_d = $signed(DOE_W'(yoe365)) + $signed(DOE_W'(yoe2_q[YOE_W-1:2]))
           - $signed(DOE_W'(div100(yoe2_q))) + DOE_W'(doy2_q);
  end

  // Stage 4: days since 1970-01-01; stage 5: seconds.
  assign days4_d = eradays2_q + DAYS_W'(doe3_q) - DAYS_TO_1970;
  assign secs5_d = EPOCH_W'(days4_q) * 39'sd86400 + EPOCH_W'(hms1_q);

  always_ff @(posedge clk_i) begin
    y1_q       <= y1_d;
    era1_q     <= era1_d;
    m153_q     <= m153_d;
    hms1_q     <= hms1_d;
    yoe2_q     <= yoe2_d;
    doy2_q     <= doy2_d;
    eradays2_q <= eradays2_d;
    doe3_q     <= doe3_d;
    days4_q    <= days4_d;
    secs5_q    <= secs5_d;
  end

  // Output word register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      epoch_q <= s_short_q ? '0 : secs5_q;
      short_q <= s_short_q;
    end
  end

  assign epoch_seconds_o = epoch_q;
  assign too_short_o     = short_q;

endmodule

/* design/iso_timestamp_to_epoch.sv */
// Top level of the timestamp text to UTC epoch seconds converter.
// Throughput: one character word per cycle while a timestamp is being collected.
// The result word is valid once the final character has passed through the snapshot
// registers, the five-stage conversion datapath and the output word register.
// Input is held off while the conversion runs, and longer while an earlier result is untaken.
// Reset clears all collected fields, the controller and the output valid flag.
module iso_timestamp_to_epoch (
  input  logic clk_i,
  input  logic rst_ni,
  ite_in_if.sink    in_i,
  ite_out_if.source out_o
);
  import ite_pkg::*;

  ite_cmd_t cmd;

  ite_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_last_i   (in_i.end_of_text),
    .in_ready_o  (in_i.ready),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .cmd_o       (cmd)
  );

  ite_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .char_code_i     (in_i.char_code),
    .cmd_i           (cmd),
    .epoch_seconds_o (out_o.epoch_seconds),
    .too_short_o     (out_o.too_short)
  );

endmodule
